### sv/key_value_table_with_rank_select_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the key/value table
// Clocked, reset-gated assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef KEY_VALUE_TABLE_WITH_RANK_SELECT_DEFINES_SVH
`define KEY_VALUE_TABLE_WITH_RANK_SELECT_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define KVT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another one in the next cycle.
`define KVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/kvt_pkg.sv
// ----------------------------------------------------------------------------
// Key/value table package
// Command and response payloads, opcodes, status codes and cell control types.
// ----------------------------------------------------------------------------
package kvt_pkg;

  localparam int unsigned OpW     = 3;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned ValW    = 32;
  localparam int unsigned RankW   = 4;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW  = 5;

  localparam logic [OpW-1:0] OP_INSERT = 3'd0;
  localparam logic [OpW-1:0] OP_UPDATE = 3'd1;
  localparam logic [OpW-1:0] OP_UPSERT = 3'd2;
  localparam logic [OpW-1:0] OP_ERASE  = 3'd3;
  localparam logic [OpW-1:0] OP_LOOKUP = 3'd4;
  localparam logic [OpW-1:0] OP_RANK   = 3'd5;

  localparam logic [StatusW-1:0] ST_OK        = 3'd0;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [StatusW-1:0] ST_PRESENT   = 3'd2;
  localparam logic [StatusW-1:0] ST_FULL      = 3'd3;
  localparam logic [StatusW-1:0] ST_RANK      = 3'd4;

  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [KeyW-1:0]  key;
    logic [ValW-1:0]  value;
    logic [RankW-1:0] rank;
  } kvt_cmd_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [KeyW-1:0]    key_out;
    logic [ValW-1:0]    value_out;
    logic [CountW-1:0]  entry_count;
  } kvt_rsp_t;

  typedef struct packed {
    logic ins;
    logic ers;
    logic upd;
  } kvt_ctrl_t;

  typedef struct packed {
    logic eq;
    logic lt;
    logic rsel;
  } kvt_flag_t;

endpackage

### sv/kvt_if.sv
// ----------------------------------------------------------------------------
// Key/value table channels
// Valid/ready channels for commands and responses.
// ----------------------------------------------------------------------------
interface kvt_cmd_if;
  logic             valid;
  logic             ready;
  kvt_pkg::kvt_cmd_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface kvt_rsp_if;
  logic             valid;
  logic             ready;
  kvt_pkg::kvt_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### sv/kvt_cell.sv
// ----------------------------------------------------------------------------
// Key/value table cell
// One slot of the sorted chain: compares on load, shifts or updates on execute.
// ----------------------------------------------------------------------------
module kvt_cell #(
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned IDX        = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  logic [KEY_BITS-1:0]       cmp_key_i,
  input  logic [kvt_pkg::RankW-1:0] rank_i,
  input  kvt_pkg::kvt_ctrl_t        ctrl_i,
  input  logic [KEY_BITS-1:0]       new_key_i,
  input  logic [VALUE_BITS-1:0]     new_val_i,
  input  logic                      left_valid_i,
  input  logic [KEY_BITS-1:0]       left_key_i,
  input  logic [VALUE_BITS-1:0]     left_val_i,
  input  logic                      left_lt_i,
  input  logic                      right_valid_i,
  input  logic [KEY_BITS-1:0]       right_key_i,
  input  logic [VALUE_BITS-1:0]     right_val_i,
  output logic                      valid_o,
  output logic [KEY_BITS-1:0]       key_o,
  output logic [VALUE_BITS-1:0]     val_o,
  output kvt_pkg::kvt_flag_t        flag_o
);
  import kvt_pkg::*;

  logic                  valid_q, valid_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  kvt_flag_t             flag_q, flag_d;

  always_comb begin
    flag_d = flag_q;
    if (load_i) begin
      flag_d.eq   = valid_q && (key_q == cmp_key_i);
      flag_d.lt   = valid_q && (key_q < cmp_key_i);
      flag_d.rsel = valid_q && (32'(rank_i) == IDX);
    end
  end

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    val_d   = val_q;
    if (ctrl_i.ins && !flag_q.lt) begin
      if (left_lt_i) begin
        valid_d = 1'b1;
        key_d   = new_key_i;
        val_d   = new_val_i;
      end else begin
        valid_d = left_valid_i;
        key_d   = left_key_i;
        val_d   = left_val_i;
      end
    end else if (ctrl_i.ers && !flag_q.lt) begin
      valid_d = right_valid_i;
      key_d   = right_key_i;
      val_d   = right_val_i;
    end else if (ctrl_i.upd && flag_q.eq) begin
      val_d = new_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      flag_q  <= '0;
    end else begin
      valid_q <= valid_d;
      flag_q  <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    val_q <= val_d;
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign val_o   = val_q;
  assign flag_o  = flag_q;

endmodule

### sv/key_value_table_with_rank_select.sv
// In the transfer cycle of a command, every cell of the sorted chain
// compares its key with the command key and its slot number with the rank;
// in the execute state the chain shifts, updates or stays, and the result
// is loaded into the response register. A new command is taken only in
// idle, so the block does not accept a command before the last one has
// executed. The execute state waits while an earlier response is still
// not taken. Entries stay sorted by ascending key and packed at the low
// end of the chain, so the entry of rank r sits in cell r.
// ----------------------------------------------------------------------------
// Key/value table with rank select
// Top level: command decode, cell chain, result selection and response register.
// ----------------------------------------------------------------------------
`include "key_value_table_with_rank_select_defines.svh"

module key_value_table_with_rank_select #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input logic      clk_i,
  input logic      rst_ni,
  kvt_cmd_if.sink   cmd_i,
  kvt_rsp_if.source rsp_o
);
  import kvt_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                  state_q, state_d;
  logic [OpW-1:0]        op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [CntW-1:0]       count_q, count_d;
  logic                  rsp_valid_q, rsp_valid_d;
  kvt_rsp_t              rsp_q, rsp_d;

  logic                  load, go;
  logic [KEY_BITS-1:0]   cmp_key;
  kvt_ctrl_t             ctrl;

  logic [CAPACITY-1:0]   cell_valid;
  logic [KEY_BITS-1:0]   cell_key [CAPACITY];
  logic [VALUE_BITS-1:0] cell_val [CAPACITY];
  kvt_flag_t             cell_flag [CAPACITY];

  logic                  hit, rank_hit, full;
  logic [KEY_BITS-1:0]   hit_key, rank_key;
  logic [VALUE_BITS-1:0] hit_val, rank_val;

  assign cmd_i.ready = (state_q == ST_IDLE);
  assign load        = cmd_i.valid && cmd_i.ready;
  assign go          = (state_q == ST_EXEC) && (!rsp_valid_q || rsp_o.ready);
  assign cmp_key     = KEY_BITS'(cmd_i.payload.key);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                  l_valid, l_lt, r_valid;
    logic [KEY_BITS-1:0]   l_key, r_key;
    logic [VALUE_BITS-1:0] l_val, r_val;

    if (i == 0) begin : g_head
      assign l_valid = 1'b0;
      assign l_key   = '0;
      assign l_val   = '0;
      assign l_lt    = 1'b1;
    end else begin : g_link_l
      assign l_valid = cell_valid[i-1];
      assign l_key   = cell_key[i-1];
      assign l_val   = cell_val[i-1];
      assign l_lt    = cell_flag[i-1].lt;
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_key   = '0;
      assign r_val   = '0;
    end else begin : g_link_r
      assign r_valid = cell_valid[i+1];
      assign r_key   = cell_key[i+1];
      assign r_val   = cell_val[i+1];
    end

    kvt_cell #(
      .KEY_BITS  (KEY_BITS),
      .VALUE_BITS(VALUE_BITS),
      .IDX       (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .load_i       (load),
      .cmp_key_i    (cmp_key),
      .rank_i       (cmd_i.payload.rank),
      .ctrl_i       (ctrl),
      .new_key_i    (key_q),
      .new_val_i    (val_q),
      .left_valid_i (l_valid),
      .left_key_i   (l_key),
      .left_val_i   (l_val),
      .left_lt_i    (l_lt),
      .right_valid_i(r_valid),
      .right_key_i  (r_key),
      .right_val_i  (r_val),
      .valid_o      (cell_valid[i]),
      .key_o        (cell_key[i]),
      .val_o        (cell_val[i]),
      .flag_o       (cell_flag[i])
    );
  end

  always_comb begin
    hit      = 1'b0;
    rank_hit = 1'b0;
    hit_key  = '0;
    hit_val  = '0;
    rank_key = '0;
    rank_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit      = hit | cell_flag[i].eq;
      rank_hit = rank_hit | cell_flag[i].rsel;
      hit_key  = hit_key | ({KEY_BITS{cell_flag[i].eq}} & cell_key[i]);
      hit_val  = hit_val | ({VALUE_BITS{cell_flag[i].eq}} & cell_val[i]);
      rank_key = rank_key | ({KEY_BITS{cell_flag[i].rsel}} & cell_key[i]);
      rank_val = rank_val | ({VALUE_BITS{cell_flag[i].rsel}} & cell_val[i]);
    end
  end

  assign full = cell_valid[CAPACITY-1];

  always_comb begin
    logic [KEY_BITS-1:0]   ko;
    logic [VALUE_BITS-1:0] vo;
    logic [StatusW-1:0]    st;
    ctrl    = '0;
    count_d = count_q;
    ko      = '0;
    vo      = '0;
    st      = ST_OK;
    unique case (op_q)
      OP_INSERT, OP_UPDATE, OP_UPSERT: begin
        if (hit) begin
          ko = hit_key;
          if (op_q == OP_INSERT) begin
            st = ST_PRESENT;
            vo = hit_val;
          end else begin
            ctrl.upd = 1'b1;
            vo       = val_q;
          end
        end else if (op_q == OP_UPDATE) begin
          st = ST_NOT_FOUND;
        end else if (full) begin
          st = ST_FULL;
        end else begin
          ctrl.ins = 1'b1;
          count_d  = count_q + 1'b1;
          ko       = key_q;
          vo       = val_q;
        end
      end
      OP_ERASE: begin
        if (hit) begin
          ctrl.ers = 1'b1;
          count_d  = count_q - 1'b1;
          ko       = hit_key;
          vo       = hit_val;
        end else begin
          st = ST_NOT_FOUND;
        end
      end
      OP_LOOKUP: begin
        if (hit) begin
          ko = hit_key;
          vo = hit_val;
        end else begin
          st = ST_NOT_FOUND;
        end
      end
      OP_RANK: begin
        if (rank_hit) begin
          ko = rank_key;
          vo = rank_val;
        end else begin
          st = ST_RANK;
        end
      end
      default: ;
    endcase
    if (!go) begin
      ctrl    = '0;
      count_d = count_q;
    end
    rsp_d.status      = st;
    rsp_d.key_out     = KeyW'(ko);
    rsp_d.value_out   = ValW'(vo);
    rsp_d.entry_count = CountW'(count_d);
  end

  always_comb begin
    state_d     = state_q;
    rsp_valid_d = rsp_valid_q;
    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: if (load) state_d = ST_EXEC;
      ST_EXEC: begin
        if (go) begin
          state_d     = ST_IDLE;
          rsp_valid_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q  <= cmd_i.payload.opcode;
      key_q <= cmp_key;
      val_q <= VALUE_BITS'(cmd_i.payload.value);
    end
    if (go) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  `KVT_ASSERT(a_count_matches_cells, $countones(cell_valid) == int'(count_q), "count != cells")
  `KVT_ASSERT(a_cells_packed, ((cell_valid + 1'b1) & cell_valid) == '0, "chain has a gap")
  `KVT_ASSERT(a_no_insert_when_full, !(ctrl.ins && full), "insert into a full chain")
  `KVT_ASSERT_NEXT(a_exec_after_load, load, state_q == ST_EXEC && !cmd_i.ready, "no execute")

endmodule
